// File: design/ptd_pkg.sv
// shared types and constants of the periodic task dispatcher
package ptd_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int IDX_W       = 3;
  localparam int TICK_W      = 32;
  localparam int CYC_W       = 32;
  localparam int PERIOD_W    = 16;
  localparam int MICROS_W    = 26;
  localparam int AVG_SHIFT   = 3;
  localparam int MICRO_SHIFT = 6;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 96;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_DONE = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [1:0] KIND_DISPATCH = 2'd0;
  localparam logic [1:0] KIND_STATS    = 2'd1;
  localparam logic [1:0] KIND_READ     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DISP,
    ST_STAT,
    ST_READ
  } state_t;

  typedef struct packed {
    logic             cap;
    logic             eval;
    logic             disp;
    logic             stat;
    logic             rd;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic out_free;
    logic mask_nz;
    logic mask_last;
  } sts_t;

endpackage

// File: design/ptd_ctrl.sv
// controller state machine of the periodic task dispatcher
module ptd_ctrl
  import ptd_pkg::*;
#(
  parameter int NUM_TASKS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.idx   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap = 1'b1;
          cnt_nxt = '0;
          unique case (sts.op)
            OP_TICK: state_nxt = ST_SCAN;
            OP_DONE: state_nxt = ST_STAT;
            OP_READ: state_nxt = ST_READ;
            OP_NONE: state_nxt = ST_IDLE;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.eval = 1'b1;
        if (int'(cnt_r) >= NUM_TASKS - 1) begin
          state_nxt = ST_DISP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DISP: begin
        if (!sts.mask_nz) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.disp = 1'b1;
          if (sts.mask_last) state_nxt = ST_IDLE;
        end
      end
      ST_STAT: begin
        if (sts.out_free) begin
          cmd.stat  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts.out_free) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: design/ptd_datapath.sv
// task table, statistics arithmetic and output register of the dispatcher
module ptd_datapath
  import ptd_pkg::*;
#(
  parameter int NUM_TASKS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [PERIOD_W-1:0]   cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  logic [PERIOD_W-1:0] period_r [SLOT_COUNT];
  logic [TICK_W-1:0]   last_r   [SLOT_COUNT];
  logic [CYC_W-1:0]    worst_r  [SLOT_COUNT];
  logic [CYC_W-1:0]    avg_r    [SLOT_COUNT];

  logic [TICK_W-1:0]     now_r;
  logic [IDX_W-1:0]      id_r;
  logic [CYC_W-1:0]      cyc_r;
  logic [SLOT_COUNT-1:0] mask_r;

  logic                out_valid_r;
  logic [1:0]          out_kind_r;
  logic [IDX_W-1:0]    out_sel_r;
  logic [CYC_W-1:0]    out_worst_r;
  logic [CYC_W-1:0]    out_mean_r;
  logic [MICROS_W-1:0] out_micros_r;
  logic                out_last_r;

  logic [TICK_W-1:0]     diff;
  logic                  due;
  logic [IDX_W-1:0]      low_idx;
  logic [SLOT_COUNT-1:0] mask_rest;
  logic                  id_ok;
  logic [CYC_W-1:0]      w_cur, a_cur, w_new, a_new;
  logic                  emit;

  assign diff      = now_r - last_r[cmd.idx];
  assign due       = diff >= {{(TICK_W-PERIOD_W){1'b0}}, period_r[cmd.idx]};
  assign mask_rest = mask_r & (mask_r - 1'b1);
  assign id_ok     = int'(id_r) < NUM_TASKS;
  assign w_cur     = worst_r[id_r];
  assign a_cur     = avg_r[id_r];
  assign w_new     = (cyc_r > w_cur) ? cyc_r : w_cur;
  assign a_new     = a_cur - (a_cur >> AVG_SHIFT) + (cyc_r >> AVG_SHIFT);
  assign emit      = cmd.disp || cmd.stat || cmd.rd;

  always_comb begin
    low_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (mask_r[i]) low_idx = IDX_W'(i);
    end
  end

  // table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        period_r[i] <= PERIOD_W'(1);
        last_r[i]   <= '0;
        worst_r[i]  <= '0;
        avg_r[i]    <= '0;
      end
    end else begin
      if (cfg_we) period_r[cfg_index] <= cfg_wdata;
      if (cmd.disp) last_r[low_idx] <= now_r;
      if (cmd.stat && id_ok) begin
        worst_r[id_r] <= w_new;
        avg_r[id_r]   <= a_new;
      end
    end
  end

  // captured transaction and due mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      if (cmd.cap) mask_r <= '0;
      else if (cmd.eval) mask_r[cmd.idx] <= due;
      else if (cmd.disp) mask_r <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      now_r <= in_tdata[31:0];
      id_r  <= in_tdata[34:32];
      cyc_r <= in_tdata[66:35];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      priority if (cmd.disp) begin
        out_kind_r   <= KIND_DISPATCH;
        out_sel_r    <= low_idx;
        out_worst_r  <= '0;
        out_mean_r   <= '0;
        out_micros_r <= '0;
        out_last_r   <= (mask_rest == '0);
      end else if (cmd.stat) begin
        out_kind_r   <= KIND_STATS;
        out_sel_r    <= id_r;
        out_worst_r  <= id_ok ? w_new : '0;
        out_mean_r   <= id_ok ? a_new : '0;
        out_micros_r <= '0;
        out_last_r   <= 1'b1;
      end else begin
        out_kind_r   <= KIND_READ;
        out_sel_r    <= id_r;
        out_worst_r  <= '0;
        out_mean_r   <= '0;
        out_micros_r <= id_ok ? w_cur[CYC_W-1:MICRO_SHIFT] : '0;
        out_last_r   <= 1'b1;
      end
    end
  end

  assign sts.op        = op_t'(in_tuser);
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.mask_nz   = (mask_r != '0);
  assign sts.mask_last = (mask_rest == '0);

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_micros_r, out_mean_r, out_worst_r, out_sel_r};

endmodule

// File: design/periodic_task_dispatcher_with_timing.sv
// top level of the periodic task dispatcher with execution statistics
//
//   channel  direction  handshake              payload
//   in_      slave      in_tvalid/in_tready    in_tdata, in_tuser
//   out_     master     out_tvalid/out_tready  out_tdata, out_tuser, out_tlast
//   cfg_     write      cfg_we                 cfg_index, cfg_wdata
//
// a tick is captured, then the table is scanned one entry per cycle through the due
// comparator, then due tasks are dispatched one per cycle while the output is free
// completion and read transactions are captured, then emit once the output is free
// reset is synchronous and returns every period to 1 and the table to zero
// a new transaction is taken whenever the controller is idle, even while a
// result still sits in the output register; stalled output holds the walk
module periodic_task_dispatcher_with_timing
  import ptd_pkg::*;
#(
  parameter int NUM_TASKS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [PERIOD_W-1:0]   cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // now_tick[31:0], task_id[34:32], cycles_taken[66:35]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // task_sel[2:0], worst_cycles[34:3], mean_cycles[66:35], worst_micros[92:67]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // result_kind[1:0]
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  cmd_t cmd;
  sts_t sts;

  ptd_ctrl #(
    .NUM_TASKS(NUM_TASKS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .sts     (sts),
    .in_ready(in_tready),
    .cmd     (cmd)
  );

  ptd_datapath #(
    .NUM_TASKS(NUM_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// File: design/ptd_checker.sv
// port-level checker of the periodic task dispatcher and its bind
module ptd_checker
  import ptd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [1:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result transaction changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != OP_NONE |=> !in_tready)
    else $error("input taken while a transaction is in progress");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == KIND_DISPATCH || out_tuser == KIND_STATS ||
                   out_tuser == KIND_READ)
    else $error("unknown result kind");

  a_dispatch_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DISPATCH |-> out_tdata[92:3] == '0)
    else $error("dispatch result carries statistics");

endmodule

bind periodic_task_dispatcher_with_timing ptd_checker u_ptd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
